[rtl/lcc_pkg.sv]
package lcc_pkg;

	localparam int SLOT_W    = 5;
	localparam int VALUE_W   = 16;
	localparam int PROD_W    = 32;
	localparam int SUM_W     = 40;
	localparam int CNT_W     = 32;
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 168;

	localparam int NUM_FEATURES_DEF = 18;
	localparam int INIT_WEIGHTS     = 18;

	// -0.35 in Q18.22
	localparam logic signed [SUM_W-1:0] BIAS_RESET = -40'sd1468006;

	typedef enum logic {
		ACT_LOAD   = 1'b0,
		ACT_SAMPLE = 1'b1
	} action_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic label;
	} ctl_t;

	// power-on weights, Q2.14
	function automatic logic signed [VALUE_W-1:0] init_weight(input logic [6:0] idx);
		logic signed [VALUE_W-1:0] w;
		case (idx)
			7'd0:    w = 16'sd1966;
			7'd1:    w = -16'sd1147;
			7'd2:    w = 16'sd819;
			7'd3:    w = 16'sd1475;
			7'd4:    w = -16'sd1802;
			7'd5:    w = 16'sd492;
			7'd6:    w = 16'sd1311;
			7'd7:    w = -16'sd328;
			7'd8:    w = 16'sd983;
			7'd9:    w = 16'sd655;
			7'd10:   w = -16'sd819;
			7'd11:   w = 16'sd1638;
			7'd12:   w = -16'sd1311;
			7'd13:   w = 16'sd1147;
			7'd14:   w = 16'sd328;
			7'd15:   w = -16'sd492;
			7'd16:   w = 16'sd1802;
			7'd17:   w = -16'sd983;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

[rtl/linear_classifier_confusion_counter.sv]
// A record's result moves from its last feature beat through s1, s2, s3 and the output register.
// Throughput: one beat per cycle; input stalls only when a second result reaches the
// last stage s3 while the previous result beat is still not taken.
// Weight memory is read at sample accept, multiply and saturating accumulate take one stage each.
// Reset: counters, record position and pipeline clear; bias returns to -0.35 and every
// weight slot reads its power-on value until loaded.
module linear_classifier_confusion_counter #(
	parameter int NUM_FEATURES = lcc_pkg::NUM_FEATURES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lcc_pkg::SUM_W-1:0]          cfg_wdata,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lcc_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // slot, value, label, pad
	input  logic                               s_axis_tuser,  // action
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lcc_pkg::M_TDATA_W-1:0]      m_axis_tdata   // predicted, positive, tp, fp,
	                                                          // tn, fn counts, pad
);
	import lcc_pkg::*;

	localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

	logic signed [SUM_W-1:0]   bias_q;
	logic [AW-1:0]             pos_q;
	logic                      accept;
	logic                      sample;
	logic                      stall;
	logic                      adv;
	logic                      first;
	logic                      last;
	logic [SLOT_W-1:0]         in_slot;
	logic signed [VALUE_W-1:0] in_value;
	logic                      in_label;
	ctl_t                      ctl_s1;
	ctl_t                      ctl_s3;
	logic signed [VALUE_W-1:0] value_s1;
	logic signed [VALUE_W-1:0] weight_s1;
	logic signed [SUM_W-1:0]   acc;

	assign in_slot  = s_axis_tdata[SLOT_W-1:0];
	assign in_value = signed'(s_axis_tdata[SLOT_W+VALUE_W-1:SLOT_W]);
	assign in_label = s_axis_tdata[SLOT_W+VALUE_W];

	assign stall         = ctl_s3.valid && ctl_s3.last && m_axis_tvalid && !m_axis_tready;
	assign adv           = !stall;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign sample        = accept && (action_t'(s_axis_tuser) == ACT_SAMPLE);
	assign first         = (pos_q == '0);
	assign last          = (pos_q == AW'(NUM_FEATURES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= BIAS_RESET;
		end else if (cfg_we) begin
			bias_q <= signed'(cfg_wdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= sample;
			ctl_s1.first <= first;
			ctl_s1.last  <= last;
			ctl_s1.label <= in_label;
			if (sample) begin
				pos_q <= last ? '0 : pos_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample) begin
			value_s1 <= in_value;
		end
	end

	lcc_weight_mem #(
		.NUM_FEATURES(NUM_FEATURES)
	) u_wmem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (accept && (action_t'(s_axis_tuser) == ACT_LOAD)),
		.waddr (in_slot),
		.wdata (in_value),
		.re    (sample),
		.raddr (pos_q),
		.rdata (weight_s1)
	);

	lcc_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.ctl_s1   (ctl_s1),
		.value_s1 (value_s1),
		.weight_s1(weight_s1),
		.bias     (bias_q),
		.ctl_s3   (ctl_s3),
		.acc      (acc)
	);

	lcc_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_s3  (ctl_s3),
		.sum_neg (acc[SUM_W-1]),
		.m_tready(m_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.m_tdata (m_axis_tdata)
	);

`ifndef NO_ASSERTIONS
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= AW'(NUM_FEATURES - 1))
		else $error("record position out of range");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(ctl_s3.valid && ctl_s3.last))
		else $error("result beat without a finished record");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> $stable(acc) && $stable(ctl_s3))
		else $error("accumulator moved during output stall");
`endif

endmodule

[rtl/lcc_weight_mem.sv]
module lcc_weight_mem #(
	parameter int NUM_FEATURES = lcc_pkg::NUM_FEATURES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 we,
	input  logic [lcc_pkg::SLOT_W-1:0]           waddr,
	input  logic signed [lcc_pkg::VALUE_W-1:0]   wdata,
	input  logic                                 re,
	input  logic [((NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1)-1:0] raddr,
	output logic signed [lcc_pkg::VALUE_W-1:0]   rdata
);
	import lcc_pkg::*;

	localparam int AW = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

	logic [VALUE_W-1:0]         mem [NUM_FEATURES];
	logic [NUM_FEATURES-1:0]    wvld_q;
	logic [AW+SLOT_W-1:0]       slot_w;
	logic                       wr_ok;
	logic [VALUE_W-1:0]         mem_s1;
	logic                       vld_s1;
	logic signed [VALUE_W-1:0]  init_s1;

	assign slot_w = (AW+SLOT_W)'(waddr);
	assign wr_ok  = we && (slot_w < (AW+SLOT_W)'(NUM_FEATURES));

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[slot_w[AW-1:0]] <= wdata;
		end
		if (re) begin
			mem_s1  <= mem[raddr];
			vld_s1  <= wvld_q[raddr];
			init_s1 <= init_weight(7'(raddr));
		end
	end

	// entries never loaded read as the power-on weight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= '0;
		end else if (wr_ok) begin
			wvld_q[slot_w[AW-1:0]] <= 1'b1;
		end
	end

	assign rdata = vld_s1 ? signed'(mem_s1) : init_s1;

endmodule

[rtl/lcc_mac.sv]
module lcc_mac (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               adv,
	input  lcc_pkg::ctl_t                      ctl_s1,
	input  logic signed [lcc_pkg::VALUE_W-1:0] value_s1,
	input  logic signed [lcc_pkg::VALUE_W-1:0] weight_s1,
	input  logic signed [lcc_pkg::SUM_W-1:0]   bias,
	output lcc_pkg::ctl_t                      ctl_s3,
	output logic signed [lcc_pkg::SUM_W-1:0]   acc
);
	import lcc_pkg::*;

	ctl_t                     ctl_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [SUM_W-1:0]  acc_q;
	logic signed [SUM_W-1:0]  base;
	logic signed [SUM_W:0]    sum_wide;
	logic signed [SUM_W-1:0]  sum_sat;

	assign base     = ctl_s2.first ? bias : acc_q;
	assign sum_wide = (SUM_W+1)'(base) + (SUM_W+1)'(prod_s2);

	always_comb begin
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= value_s1 * weight_s1;
			if (ctl_s2.valid) begin
				acc_q <= sum_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	assign acc = acc_q;

endmodule

[rtl/lcc_tally.sv]
module lcc_tally (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  lcc_pkg::ctl_t                        ctl_s3,
	input  logic                                 sum_neg,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [lcc_pkg::M_TDATA_W-1:0]        m_tdata
);
	import lcc_pkg::*;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == '1) ? c : c + CNT_W'(1);
	endfunction

	logic             done;
	logic             pred;
	logic [CNT_W-1:0] pos_q, tp_q, fp_q, tn_q, fn_q;
	logic [CNT_W-1:0] pos_d, tp_d, fp_d, tn_d, fn_d;
	logic             m_tvalid_q;
	logic [M_TDATA_W-1:0] m_tdata_q;

	assign done = adv && ctl_s3.valid && ctl_s3.last;
	assign pred = !sum_neg;

	always_comb begin
		pos_d = pred ? sat_inc(pos_q) : pos_q;
		tp_d  = (pred && ctl_s3.label)   ? sat_inc(tp_q) : tp_q;
		fp_d  = (pred && !ctl_s3.label)  ? sat_inc(fp_q) : fp_q;
		tn_d  = (!pred && !ctl_s3.label) ? sat_inc(tn_q) : tn_q;
		fn_d  = (!pred && ctl_s3.label)  ? sat_inc(fn_q) : fn_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			tp_q       <= '0;
			fp_q       <= '0;
			tn_q       <= '0;
			fn_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (done) begin
				pos_q      <= pos_d;
				tp_q       <= tp_d;
				fp_q       <= fp_d;
				tn_q       <= tn_d;
				fn_q       <= fn_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= {7'b0, fn_d, tn_d, fp_d, tp_d, pos_d, pred};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
